/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// implication or plain property, sampled on the rising clock edge
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// condition that must never hold
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

/* design/srs_pkg.sv */
// ----------------------------------------------------------------------------
// srs_pkg
// shared types, codes and ring helpers of the suspend/resume sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srs_pkg;

  localparam int QueueDepth = 8;
  localparam int PtrW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW       = $clog2(QueueDepth + 1);

  localparam logic [15:0] DeadlineReset = 16'd5000;

  typedef enum logic [2:0] {
    OP_SUSPEND_REQ = 3'd0,
    OP_RESUME_REQ  = 3'd1,
    OP_PUMP        = 3'd2,
    OP_SUSPEND_DONE = 3'd3,
    OP_RESUME_DONE = 3'd4,
    OP_SAFETY_FIRED = 3'd5,
    OP_ARM_FAILED  = 3'd6,
    OP_RESERVED    = 3'd7
  } opcode_e;

  typedef enum logic [1:0] {
    CFG_LOCK_SOURCE = 2'd0,
    CFG_DEADLINE    = 2'd1
  } cfg_index_e;

  typedef enum logic [1:0] {
    WORK_NONE    = 2'd0,
    WORK_SUSPEND = 2'd1,
    WORK_RESUME  = 2'd2
  } work_e;

  typedef enum logic [1:0] {
    TIMER_NONE   = 2'd0,
    TIMER_ARM    = 2'd1,
    TIMER_DISARM = 2'd2
  } timer_e;

  typedef enum logic [1:0] {
    NOTIFY_NONE    = 2'd0,
    NOTIFY_SUSPEND = 2'd1,
    NOTIFY_RESUME  = 2'd2
  } notify_e;

  typedef enum logic [1:0] {
    LOCK_NONE    = 2'd0,
    LOCK_TAKE    = 2'd1,
    LOCK_RELEASE = 2'd2
  } lock_e;

  typedef enum logic [1:0] {
    SAFETY_NONE    = 2'd0,
    SAFETY_FIRED   = 2'd1,
    SAFETY_OVERRUN = 2'd2
  } safety_e;

  // ring entry: kind bit (1 = resume) and source id
  typedef struct packed {
    logic       kind;
    logic [1:0] src;
  } ring_ent_t;

  // wrap a head + offset sum back into the ring
  function automatic logic [PtrW-1:0] ring_wrap(logic [PtrW:0] idx);
    logic [PtrW:0] depth;
    depth = (PtrW+1)'(QueueDepth);
    if (idx >= depth) begin
      return PtrW'(idx - depth);
    end
    return PtrW'(idx);
  endfunction

endpackage

/* design/suspend_resume_sequencer.sv */
// ----------------------------------------------------------------------------
// suspend_resume_sequencer
// queues suspend/resume requests and sequences work, timer, lock and notify
// ----------------------------------------------------------------------------
// usage
//   events enter on start_i with opcode_i and requester_i; a transaction is
//   taken at every rising edge where start_i is high and busy_o is low.
//   busy_o stays low, so one event can be taken in every cycle.
//   every event gives exactly one result: result_valid_o is high for one
//   cycle with work_o, timer_action_o, timer_delay_ms_o, reconnect_notify_o,
//   lock_action_o, safety_outcome_o and dropped_o. the receiver cannot stall.
//   the event is captured in the input register when it is accepted and the
//   result register is loaded in the following cycle; the result register
//   also holds the updated phase, ring pointers and head read.
//   throughput is one event per cycle, set by the single pass between those
//   two registers and the one-read, one-write pending ring.
//   configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
//   index 0 is the lock source, index 1 the safety deadline, others ignored.
//   reset (rst_ni low) empties the ring, returns to idle, sets lock source 0
//   and a deadline of 5000 ms; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module suspend_resume_sequencer
  import srs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  opcode_i,
  input  logic [1:0]  requester_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [1:0]  work_o,
  output logic [1:0]  timer_action_o,
  output logic [15:0] timer_delay_ms_o,
  output logic [1:0]  reconnect_notify_o,
  output logic [1:0]  lock_action_o,
  output logic [1:0]  safety_outcome_o,
  output logic        dropped_o
);

`include "assert_macros.svh"

  typedef enum logic [1:0] {
    PH_IDLE       = 2'd0,
    PH_SUSPENDING = 2'd1,
    PH_RESUMING   = 2'd2
  } phase_e;

  // configuration
  logic [1:0]  lock_source_q;
  logic [15:0] deadline_q;

  // input register
  logic        s1_valid_q;
  opcode_e     s1_op_q;
  logic [1:0]  s1_src_q;

  // sequencer state
  phase_e          phase_q, phase_d;
  logic [1:0]      active_q, active_d;
  logic            fired_q, fired_d;
  logic [PtrW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;
  ring_ent_t       tail_q, tail_d;

  // pending ring
  ring_ent_t       ring_q [QueueDepth];
  ring_ent_t       head_rd_q;
  logic            wr_en;
  logic [PtrW-1:0] wr_addr;
  ring_ent_t       req_ent;
  logic            coalesce;

  // result
  work_e   work_d;
  timer_e  tact_d;
  logic [15:0] tdel_d;
  notify_e notify_d;
  lock_e   lock_d;
  safety_e safe_d;
  logic    drop_d;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_source_q <= 2'd0;
      deadline_q    <= DeadlineReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_LOCK_SOURCE: lock_source_q <= cfg_data_i[1:0];
        CFG_DEADLINE:    deadline_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_op_q    <= OP_ARM_FAILED;
      s1_src_q   <= 2'd0;
    end else begin
      s1_valid_q <= start_i && !busy_o;
      s1_op_q    <= opcode_e'(opcode_i);
      s1_src_q   <= requester_i;
    end
  end

  assign req_ent = '{kind: s1_op_q[0], src: s1_src_q};

  always_comb begin
    if (count_q != '0) begin
      coalesce = (tail_q == req_ent);
    end else begin
      coalesce = ((phase_q == PH_SUSPENDING) && !req_ent.kind && (active_q == s1_src_q))
              || ((phase_q == PH_RESUMING) && req_ent.kind && (active_q == s1_src_q));
    end
  end

  assign wr_addr = ring_wrap({1'b0, head_q} + (PtrW+1)'(count_q));

  always_comb begin
    phase_d  = phase_q;
    active_d = active_q;
    fired_d  = fired_q;
    head_d   = head_q;
    count_d  = count_q;
    tail_d   = tail_q;
    wr_en    = 1'b0;
    work_d   = WORK_NONE;
    tact_d   = TIMER_NONE;
    tdel_d   = 16'd0;
    notify_d = NOTIFY_NONE;
    lock_d   = LOCK_NONE;
    safe_d   = SAFETY_NONE;
    drop_d   = 1'b0;
    if (s1_valid_q) begin
      case (s1_op_q)
        OP_SUSPEND_REQ, OP_RESUME_REQ: begin
          if (!coalesce) begin
            if (count_q == CntW'(QueueDepth)) begin
              drop_d = 1'b1;
            end else begin
              wr_en   = 1'b1;
              tail_d  = req_ent;
              count_d = count_q + CntW'(1);
            end
          end
        end
        OP_PUMP: begin
          if ((phase_q == PH_IDLE) && (count_q != '0)) begin
            head_d   = ring_wrap({1'b0, head_q} + (PtrW+1)'(1));
            count_d  = count_q - CntW'(1);
            active_d = head_rd_q.src;
            if (!head_rd_q.kind) begin
              phase_d  = PH_SUSPENDING;
              fired_d  = 1'b0;
              work_d   = WORK_SUSPEND;
              tact_d   = TIMER_ARM;
              tdel_d   = deadline_q;
              notify_d = NOTIFY_SUSPEND;
            end else begin
              phase_d  = PH_RESUMING;
              work_d   = WORK_RESUME;
              notify_d = NOTIFY_RESUME;
            end
          end
        end
        OP_SUSPEND_DONE: begin
          if (phase_q == PH_SUSPENDING) begin
            phase_d = PH_IDLE;
            fired_d = 1'b0;
            tact_d  = TIMER_DISARM;
            if (fired_q) begin
              safe_d = SAFETY_OVERRUN;
            end else if (active_q == lock_source_q) begin
              lock_d = LOCK_RELEASE;
            end
          end
        end
        OP_RESUME_DONE: begin
          if (phase_q == PH_RESUMING) begin
            phase_d = PH_IDLE;
            if (active_q == lock_source_q) begin
              lock_d = LOCK_TAKE;
            end
          end
        end
        OP_SAFETY_FIRED: begin
          if ((phase_q == PH_SUSPENDING) && !fired_q) begin
            fired_d = 1'b1;
            safe_d  = SAFETY_FIRED;
            if (active_q == lock_source_q) begin
              lock_d = LOCK_RELEASE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // ring storage, head entry read ahead with write forwarding
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_q[wr_addr] <= req_ent;
    end
    if (wr_en && (wr_addr == head_d)) begin
      head_rd_q <= req_ent;
    end else begin
      head_rd_q <= ring_q[head_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q            <= PH_IDLE;
      active_q           <= 2'd0;
      fired_q            <= 1'b0;
      head_q             <= '0;
      count_q            <= '0;
      tail_q             <= '0;
      result_valid_o     <= 1'b0;
      work_o             <= WORK_NONE;
      timer_action_o     <= TIMER_NONE;
      timer_delay_ms_o   <= 16'd0;
      reconnect_notify_o <= NOTIFY_NONE;
      lock_action_o      <= LOCK_NONE;
      safety_outcome_o   <= SAFETY_NONE;
      dropped_o          <= 1'b0;
    end else begin
      phase_q            <= phase_d;
      active_q           <= active_d;
      fired_q            <= fired_d;
      head_q             <= head_d;
      count_q            <= count_d;
      tail_q             <= tail_d;
      result_valid_o     <= s1_valid_q;
      work_o             <= work_d;
      timer_action_o     <= tact_d;
      timer_delay_ms_o   <= tdel_d;
      reconnect_notify_o <= notify_d;
      lock_action_o      <= lock_d;
      safety_outcome_o   <= safe_d;
      dropped_o          <= drop_d;
    end
  end

  `ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > CntW'(QueueDepth))
  `ASSERT_PROP(a_one_result, clk_i, rst_ni, s1_valid_q |=> result_valid_o)
  `ASSERT_PROP(a_drop_full, clk_i, rst_ni, dropped_o |-> (count_q == CntW'(QueueDepth)))
  `ASSERT_PROP(a_suspend_phase, clk_i, rst_ni,
               (work_o == WORK_SUSPEND) |-> (phase_q == PH_SUSPENDING))
  `ASSERT_PROP(a_arm_delay, clk_i, rst_ni,
               (timer_action_o == TIMER_ARM) |-> (timer_delay_ms_o == deadline_q))

endmodule

/* tb/sv/tb_suspend_resume_sequencer.sv */
// ----------------------------------------------------------------------------
// tb_suspend_resume_sequencer
// drives suspend/resume events and register writes into the sequencer and
// checks every result against a cycle-free model of the queue, phase, timer
// and lock behavior kept in a small scoreboard
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_suspend_resume_sequencer
  import srs_pkg::*;
();

  localparam int          CycleLimit = 400000;
  localparam int          PhaseItems = 250;
  localparam logic [1:0]  CfgSpareA  = 2'd2;
  localparam logic [1:0]  CfgSpareB  = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE       = 2'd0,
    PH_SUSPENDING = 2'd1,
    PH_RESUMING   = 2'd2
  } phase_e;

  typedef struct packed {
    work_e       work;
    timer_e      timer;
    logic [15:0] delay;
    notify_e     notify;
    lock_e       lock;
    safety_e     safety;
    logic        dropped;
  } outcome_t;

  class sequencer_scoreboard;
    outcome_t    expected_outcomes[$];
    int          errors;
    logic [1:0]  lock_src;
    logic [15:0] deadline;
    phase_e      phase;
    logic [1:0]  owner;
    bit          fired;
    ring_ent_t   ring[QueueDepth];
    int          head;
    int          depth;

    function new();
      errors   = 0;
      lock_src = 2'd0;
      deadline = DeadlineReset;
      phase    = PH_IDLE;
      owner    = 2'd0;
      fired    = 1'b0;
      head     = 0;
      depth    = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        CFG_LOCK_SOURCE: lock_src = data[1:0];
        CFG_DEADLINE:    deadline = data;
        default: ;
      endcase
    endfunction

    function int slot(int offset);
      int i;
      i = head + offset;
      if (i >= QueueDepth) begin
        i -= QueueDepth;
      end
      return i;
    endfunction

    function bit merges(ring_ent_t ent);
      if (depth != 0) begin
        return ring[slot(depth - 1)] == ent;
      end
      if (phase == PH_SUSPENDING) begin
        return !ent.kind && owner == ent.src;
      end
      if (phase == PH_RESUMING) begin
        return ent.kind && owner == ent.src;
      end
      return 1'b0;
    endfunction

    function void note_event(opcode_e op, logic [1:0] who);
      outcome_t  r;
      ring_ent_t ent;
      r = '0;
      case (op)
        OP_SUSPEND_REQ, OP_RESUME_REQ: begin
          ent.kind = (op == OP_RESUME_REQ);
          ent.src  = who;
          if (!merges(ent)) begin
            if (depth == QueueDepth) begin
              r.dropped = 1'b1;
            end else begin
              ring[slot(depth)] = ent;
              depth++;
            end
          end
        end
        OP_PUMP: begin
          if (phase == PH_IDLE && depth != 0) begin
            ent   = ring[head];
            head  = slot(1);
            depth--;
            owner = ent.src;
            if (!ent.kind) begin
              phase    = PH_SUSPENDING;
              fired    = 1'b0;
              r.work   = WORK_SUSPEND;
              r.timer  = TIMER_ARM;
              r.delay  = deadline;
              r.notify = NOTIFY_SUSPEND;
            end else begin
              phase    = PH_RESUMING;
              r.work   = WORK_RESUME;
              r.notify = NOTIFY_RESUME;
            end
          end
        end
        OP_SUSPEND_DONE: begin
          if (phase == PH_SUSPENDING) begin
            phase   = PH_IDLE;
            r.timer = TIMER_DISARM;
            if (fired) begin
              r.safety = SAFETY_OVERRUN;
            end else if (owner == lock_src) begin
              r.lock = LOCK_RELEASE;
            end
            fired = 1'b0;
          end
        end
        OP_RESUME_DONE: begin
          if (phase == PH_RESUMING) begin
            phase = PH_IDLE;
            if (owner == lock_src) begin
              r.lock = LOCK_TAKE;
            end
          end
        end
        OP_SAFETY_FIRED: begin
          if (phase == PH_SUSPENDING && !fired) begin
            fired    = 1'b1;
            r.safety = SAFETY_FIRED;
            if (owner == lock_src) begin
              r.lock = LOCK_RELEASE;
            end
          end
        end
        default: ;
      endcase
      expected_outcomes.insert(expected_outcomes.size(), r);
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_outcome(outcome_t got);
      outcome_t want;
      if (expected_outcomes.size() == 0) begin
        $display("%0t: result with nothing expected, actual %p", $time, got);
        errors++;
        return;
      end
      want = expected_outcomes[0];
      expected_outcomes.delete(0);
      compare_field("work", want.work, got.work);
      compare_field("timer_action", want.timer, got.timer);
      compare_field("timer_delay_ms", want.delay, got.delay);
      compare_field("reconnect_notify", want.notify, got.notify);
      compare_field("lock_action", want.lock, got.lock);
      compare_field("safety_outcome", want.safety, got.safety);
      compare_field("dropped", want.dropped, got.dropped);
    endfunction

    function int outstanding();
      return expected_outcomes.size();
    endfunction
  endclass

  logic        clk_i              = 1'b0;
  logic        rst_ni             = 1'b0;
  logic        start_i            = 1'b0;
  logic [2:0]  opcode_i           = 3'd0;
  logic [1:0]  requester_i        = 2'd0;
  logic        cfg_valid_i        = 1'b0;
  logic [1:0]  cfg_index_i        = 2'd0;
  logic [15:0] cfg_data_i         = 16'd0;
  logic        busy_o;
  logic        cfg_ready_o;
  logic        result_valid_o;
  logic [1:0]  work_o;
  logic [1:0]  timer_action_o;
  logic [15:0] timer_delay_ms_o;
  logic [1:0]  reconnect_notify_o;
  logic [1:0]  lock_action_o;
  logic [1:0]  safety_outcome_o;
  logic        dropped_o;

  sequencer_scoreboard sb = new();
  bit                  gaps_on = 1'b1;

  suspend_resume_sequencer dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .opcode_i           (opcode_i),
    .requester_i        (requester_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .result_valid_o     (result_valid_o),
    .work_o             (work_o),
    .timer_action_o     (timer_action_o),
    .timer_delay_ms_o   (timer_delay_ms_o),
    .reconnect_notify_o (reconnect_notify_o),
    .lock_action_o      (lock_action_o),
    .safety_outcome_o   (safety_outcome_o),
    .dropped_o          (dropped_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin : result_monitor
    outcome_t got;
    if (rst_ni === 1'b1 && result_valid_o === 1'b1) begin
      got.work    = work_e'(work_o);
      got.timer   = timer_e'(timer_action_o);
      got.delay   = timer_delay_ms_o;
      got.notify  = notify_e'(reconnect_notify_o);
      got.lock    = lock_e'(lock_action_o);
      got.safety  = safety_e'(safety_outcome_o);
      got.dropped = dropped_o;
      sb.check_outcome(got);
    end
  end

  function automatic int gap_len();
    int r;
    if (!gaps_on) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.set_reg(idx, data);
  endtask

  task automatic end_reg_writes();
    cfg_valid_i <= 1'b0;
  endtask

  task automatic post_event(input opcode_e op, input logic [1:0] who);
    opcode_i    <= op;
    requester_i <= who;
    start_i     <= 1'b1;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    sb.note_event(op, who);
  endtask

  task automatic idle_for(input int n);
    if (n > 0) begin
      start_i     <= 1'b0;
      opcode_i    <= 3'($urandom);
      requester_i <= 2'($urandom);
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic issue(input opcode_e op, input logic [1:0] who);
    post_event(op, who);
    idle_for(gap_len());
  endtask

  task automatic settle();
    start_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic opcode_e pick_opcode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      return opcode_e'($urandom_range(0, 7));
    end
    if (r < 45) begin
      return $urandom_range(0, 1) ? OP_RESUME_REQ : OP_SUSPEND_REQ;
    end
    case (sb.phase)
      PH_SUSPENDING: begin
        if (r < 75) begin
          return OP_SUSPEND_DONE;
        end
        return (r < 90) ? OP_SAFETY_FIRED : OP_RESUME_DONE;
      end
      PH_RESUMING:   return (r < 85) ? OP_RESUME_DONE : OP_SUSPEND_DONE;
      default:       return OP_PUMP;
    endcase
  endfunction

  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk_i);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int          ph;
    int          sent;
    int          n;
    logic [1:0]  lock;
    logic [15:0] deadline;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_reg(CFG_LOCK_SOURCE, 16'hFFFF);
    write_reg(CFG_DEADLINE, 16'hFFFF);
    write_reg(CfgSpareA, 16'($urandom));
    write_reg(CfgSpareB, 16'($urandom));
    end_reg_writes();

    // no-ops and events in the wrong phase
    issue(OP_RESERVED, 2'd3);
    issue(OP_ARM_FAILED, 2'd2);
    issue(OP_PUMP, 2'd1);
    issue(OP_SUSPEND_DONE, 2'd0);
    issue(OP_RESUME_DONE, 2'd3);
    issue(OP_SAFETY_FIRED, 2'd0);
    // tail merge, suspend with safety firing, resume merged with active phase
    issue(OP_SUSPEND_REQ, 2'd3);
    issue(OP_SUSPEND_REQ, 2'd3);
    issue(OP_RESUME_REQ, 2'd3);
    issue(OP_PUMP, 2'd0);
    issue(OP_PUMP, 2'd2);
    issue(OP_RESUME_DONE, 2'd1);
    issue(OP_SAFETY_FIRED, 2'd1);
    issue(OP_SAFETY_FIRED, 2'd2);
    issue(OP_SUSPEND_DONE, 2'd3);
    issue(OP_PUMP, 2'd0);
    issue(OP_RESUME_REQ, 2'd3);
    issue(OP_RESUME_DONE, 2'd0);
    // fill the ring, last request is dropped
    for (int i = 0; i < QueueDepth + 1; i++) begin
      issue(i[0] ? OP_RESUME_REQ : OP_SUSPEND_REQ, 2'(i));
    end

    for (ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: begin
          lock     = 2'd0;
          deadline = 16'd0;
        end
        1: begin
          lock     = 2'd3;
          deadline = 16'hFFFF;
        end
        default: begin
          lock     = 2'($urandom);
          deadline = 16'($urandom);
        end
      endcase
      write_reg(CFG_LOCK_SOURCE, {14'($urandom), lock});
      write_reg(CFG_DEADLINE, deadline);
      write_reg($urandom_range(0, 1) ? CfgSpareA : CfgSpareB, 16'($urandom));
      end_reg_writes();
      gaps_on = (ph != 2 && ph != 4);
      sent    = 0;
      while (sent < PhaseItems) begin
        if ($urandom_range(0, 39) == 0) begin
          // burst of alternating requests to push the ring to full
          n = $urandom_range(QueueDepth + 1, QueueDepth + 4);
          for (int k = 0; k < n; k++) begin
            issue(k[0] ? OP_RESUME_REQ : OP_SUSPEND_REQ, 2'($urandom));
          end
          sent += n;
        end else begin
          issue(pick_opcode(), 2'($urandom));
          sent++;
        end
      end
    end
    settle();

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
